// ===== rtl/ppmp_pkg.sv =====
// Shared types and codes of the PPM P3 ASCII stream parser.
package ppmp_pkg;

    // Result kinds
    localparam logic [2:0] KIND_NONE   = 3'd0;
    localparam logic [2:0] KIND_HEADER = 3'd1;
    localparam logic [2:0] KIND_PIXEL  = 3'd2;
    localparam logic [2:0] KIND_DONE   = 3'd3;
    localparam logic [2:0] KIND_ERROR  = 3'd4;

    // Sticky error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_P6        = 3'd1;
    localparam logic [2:0] ERR_BAD_CHAR  = 3'd2;
    localparam logic [2:0] ERR_RANGE     = 3'd3;
    localparam logic [2:0] ERR_MAXVAL    = 3'd4;
    localparam logic [2:0] ERR_SAMPLE    = 3'd5;
    localparam logic [2:0] ERR_TOO_MANY  = 3'd6;
    localparam logic [2:0] ERR_TOO_FEW   = 3'd7;

    // Largest legal sample or maxval
    localparam logic [16:0] SAMPLE_LIMIT = 17'd65536;

    // Output tdata layout, lowest bit first
    localparam int TDATA_W   = 104;
    localparam int ERR_LSB   = 100;
    localparam int ERR_MSB   = 102;

    // One result item
    typedef struct packed {
        logic [2:0]  kind;
        logic [16:0] red;
        logic [16:0] green;
        logic [16:0] blue;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [16:0] max_value;
        logic [2:0]  error_code;
    } result_t;

endpackage

// ===== rtl/ppmp_parser.sv =====
// Byte-at-a-time tokenizer, header decoder and pixel assembler.
module ppmp_parser #(
    parameter int MAX_TOKEN_LEN = 16,
    parameter int DIM_BITS      = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_accept,
    input  logic [7:0]         in_byte,
    input  logic               in_last,
    output ppmp_pkg::result_t  result
);

    localparam int CntW = $clog2(MAX_TOKEN_LEN + 1);
    localparam logic [CntW-1:0] TokenMax = CntW'(MAX_TOKEN_LEN);
    localparam logic [16:0] DimMax = 17'((64'd1 << DIM_BITS) - 64'd1);
    localparam logic [16:0] ValueSat = 17'd65537;
    localparam logic [32:0] CountMax = {33{1'b1}};

    // Parse phases
    localparam logic [2:0] PH_MAGIC  = 3'd0;
    localparam logic [2:0] PH_WIDTH  = 3'd1;
    localparam logic [2:0] PH_HEIGHT = 3'd2;
    localparam logic [2:0] PH_MAXVAL = 3'd3;
    localparam logic [2:0] PH_PIXELS = 3'd4;

    // Magic token match progress
    localparam logic [2:0] MM_NONE  = 3'd0;
    localparam logic [2:0] MM_P     = 3'd1;
    localparam logic [2:0] MM_P3    = 3'd2;
    localparam logic [2:0] MM_P6    = 3'd3;
    localparam logic [2:0] MM_OTHER = 3'd4;

    // Characters of interest
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_3     = 8'h33;
    localparam logic [7:0] CH_6     = 8'h36;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    logic [2:0]            phase_reg, phase_next;
    logic                  in_token_reg, in_token_next;
    logic                  in_comment_reg, in_comment_next;
    logic [2:0]            magic_reg, magic_next;
    logic [16:0]           value_reg, value_next;
    logic                  bad_reg, bad_next;
    logic                  long_reg, long_next;
    logic [CntW-1:0]       count_reg, count_next;
    logic [DIM_BITS-1:0]   width_reg, width_next;
    logic [DIM_BITS-1:0]   height_reg, height_next;
    logic [16:0]           maxval_reg, maxval_next;
    logic [1:0]            channel_reg, channel_next;
    logic [16:0]           red_reg, red_next;
    logic [16:0]           green_reg, green_next;
    logic [32:0]           pixels_reg, pixels_next;
    logic [2:0]            error_reg, error_next;
    logic [2*DIM_BITS-1:0] need_count;

    logic        is_space;
    logic        is_hash;
    logic        is_digit;
    logic        running;
    logic        add_char;
    logic        end_now;
    logic [20:0] scaled;
    logic [2:0]  kind;
    logic [16:0] out_red;
    logic [16:0] out_green;
    logic [16:0] out_blue;

    // Value of the token being closed, including a character added this cycle
    function automatic logic [16:0] tok_value(input logic add, input logic digit,
                                              input logic [20:0] sc,
                                              input logic [16:0] cur);
        logic [16:0] v;
        begin
            v = cur;
            if (add && digit)
            begin
                v = (sc > {4'd0, ValueSat}) ? ValueSat : sc[16:0];
            end
            return v;
        end
    endfunction

    // Magic match of the token being closed, including a character added this cycle
    function automatic logic [2:0] magic_next_tok(input logic add, input logic [2:0] cur,
                                                  input logic [7:0] c,
                                                  input logic [CntW-1:0] cnt);
        logic [2:0] m;
        begin
            m = cur;
            if (add)
            begin
                if (cnt == '0)
                begin
                    m = (c == CH_P) ? MM_P : MM_OTHER;
                end
                else if (cur == MM_P)
                begin
                    m = (c == CH_3) ? MM_P3 : (c == CH_6) ? MM_P6 : MM_OTHER;
                end
                else
                begin
                    m = MM_OTHER;
                end
            end
            return m;
        end
    endfunction

    // Classify the incoming byte
    assign is_space = (in_byte == CH_SPACE) || ((in_byte >= CH_TAB) && (in_byte <= CH_CR));
    assign is_hash  = (in_byte == CH_HASH);
    assign is_digit = (in_byte >= CH_0) && (in_byte <= CH_9);
    assign running  = (error_reg == ppmp_pkg::ERR_NONE);
    assign add_char = running && !in_comment_reg && !is_space && !is_hash;
    assign scaled   = {1'b0, value_reg, 3'b000} + {3'b000, value_reg, 1'b0}
                      + {17'd0, in_byte[3:0]};

    // Pixel total the header asks for
    assign need_count = {{DIM_BITS{1'b0}}, width_reg} * {{DIM_BITS{1'b0}}, height_reg};

    // Update the token and parse state for one byte
    always_comb
    begin
        phase_next      = phase_reg;
        in_token_next   = in_token_reg;
        in_comment_next = in_comment_reg;
        magic_next      = magic_reg;
        value_next      = value_reg;
        bad_next        = bad_reg;
        long_next       = long_reg;
        count_next      = count_reg;
        width_next      = width_reg;
        height_next     = height_reg;
        maxval_next     = maxval_reg;
        channel_next    = channel_reg;
        red_next        = red_reg;
        green_next      = green_reg;
        pixels_next     = pixels_reg;
        error_next      = error_reg;
        kind            = ppmp_pkg::KIND_NONE;
        out_red         = 17'd0;
        out_green       = 17'd0;
        out_blue        = 17'd0;

        // Track comments
        if (running && in_comment_reg && (in_byte == CH_LF))
        begin
            in_comment_next = 1'b0;
        end
        if (running && !in_comment_reg && is_hash)
        begin
            in_comment_next = 1'b1;
        end

        // Append a character to the open token
        if (add_char)
        begin
            if (count_reg == '0)
            begin
                magic_next = (in_byte == CH_P) ? MM_P : MM_OTHER;
            end
            else if (magic_reg == MM_P)
            begin
                magic_next = (in_byte == CH_3) ? MM_P3 :
                             (in_byte == CH_6) ? MM_P6 : MM_OTHER;
            end
            else
            begin
                magic_next = MM_OTHER;
            end
            if (count_reg >= TokenMax)
            begin
                long_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + CntW'(1);
            end
            if (is_digit)
            begin
                value_next = (scaled > {4'd0, ValueSat}) ? ValueSat : scaled[16:0];
            end
            else
            begin
                bad_next = 1'b1;
            end
            in_token_next = 1'b1;
        end

        // Close the token on a separator or at end of stream
        end_now = running && in_token_next
                  && (in_last || (!in_comment_reg && (is_space || is_hash)));
        if (end_now)
        begin
            in_token_next = 1'b0;
            value_next    = 17'd0;
            bad_next      = 1'b0;
            long_next     = 1'b0;
            count_next    = '0;
            magic_next    = MM_NONE;
            if (phase_reg == PH_MAGIC)
            begin
                if (magic_next_tok(add_char, magic_reg, in_byte, count_reg) == MM_P6)
                begin
                    error_next = ppmp_pkg::ERR_P6;
                    kind       = ppmp_pkg::KIND_ERROR;
                end
                else if (magic_next_tok(add_char, magic_reg, in_byte, count_reg) == MM_P3)
                begin
                    phase_next = PH_WIDTH;
                end
            end
            else if (add_char ? (bad_reg || !is_digit) : bad_reg)
            begin
                error_next = ppmp_pkg::ERR_BAD_CHAR;
                kind       = ppmp_pkg::KIND_ERROR;
            end
            else if (add_char ? (long_reg || (count_reg >= TokenMax)) : long_reg)
            begin
                error_next = ppmp_pkg::ERR_RANGE;
                kind       = ppmp_pkg::KIND_ERROR;
            end
            else
            begin
                unique case (phase_reg)
                    PH_WIDTH, PH_HEIGHT:
                    begin
                        if (tok_value(add_char, is_digit, scaled, value_reg) > DimMax)
                        begin
                            error_next = ppmp_pkg::ERR_RANGE;
                            kind       = ppmp_pkg::KIND_ERROR;
                        end
                        else if (phase_reg == PH_WIDTH)
                        begin
                            width_next = DIM_BITS'(tok_value(add_char, is_digit, scaled,
                                                             value_reg));
                            phase_next = PH_HEIGHT;
                        end
                        else
                        begin
                            height_next = DIM_BITS'(tok_value(add_char, is_digit, scaled,
                                                              value_reg));
                            phase_next  = PH_MAXVAL;
                        end
                    end
                    PH_MAXVAL:
                    begin
                        if (tok_value(add_char, is_digit, scaled, value_reg)
                            > ppmp_pkg::SAMPLE_LIMIT)
                        begin
                            error_next = ppmp_pkg::ERR_MAXVAL;
                            kind       = ppmp_pkg::KIND_ERROR;
                        end
                        else
                        begin
                            maxval_next = tok_value(add_char, is_digit, scaled, value_reg);
                            phase_next  = PH_PIXELS;
                            kind        = ppmp_pkg::KIND_HEADER;
                        end
                    end
                    default:
                    begin
                        if (tok_value(add_char, is_digit, scaled, value_reg) > maxval_reg)
                        begin
                            error_next = ppmp_pkg::ERR_SAMPLE;
                            kind       = ppmp_pkg::KIND_ERROR;
                        end
                        else if (channel_reg == 2'd0)
                        begin
                            red_next     = tok_value(add_char, is_digit, scaled, value_reg);
                            channel_next = 2'd1;
                        end
                        else if (channel_reg == 2'd1)
                        begin
                            green_next   = tok_value(add_char, is_digit, scaled, value_reg);
                            channel_next = 2'd2;
                        end
                        else
                        begin
                            kind         = ppmp_pkg::KIND_PIXEL;
                            out_red      = red_reg;
                            out_green    = green_reg;
                            out_blue     = tok_value(add_char, is_digit, scaled, value_reg);
                            channel_next = 2'd0;
                            if (pixels_reg != CountMax)
                            begin
                                pixels_next = pixels_reg + 33'd1;
                            end
                        end
                    end
                endcase
            end
        end

        // Check the pixel total at end of stream
        if (in_last)
        begin
            in_comment_next = 1'b0;
            if (error_next == ppmp_pkg::ERR_NONE)
            begin
                if (phase_next != PH_PIXELS)
                begin
                    error_next = ppmp_pkg::ERR_TOO_FEW;
                end
                else if (pixels_next > 33'(need_count))
                begin
                    error_next = ppmp_pkg::ERR_TOO_MANY;
                end
                else if (pixels_next < 33'(need_count))
                begin
                    error_next = ppmp_pkg::ERR_TOO_FEW;
                end
            end
            kind = (error_next != ppmp_pkg::ERR_NONE) ? ppmp_pkg::KIND_ERROR
                                                      : ppmp_pkg::KIND_DONE;
        end

        result.kind         = kind;
        result.red          = out_red;
        result.green        = out_green;
        result.blue         = out_blue;
        result.image_width  = 16'(width_next);
        result.image_height = 16'(height_next);
        result.max_value    = maxval_next;
        result.error_code   = error_next;
    end

    // Hold parse state; restart after the last byte of a file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_MAGIC;
            in_token_reg   <= 1'b0;
            in_comment_reg <= 1'b0;
            magic_reg      <= MM_NONE;
            value_reg      <= 17'd0;
            bad_reg        <= 1'b0;
            long_reg       <= 1'b0;
            count_reg      <= '0;
            width_reg      <= '0;
            height_reg     <= '0;
            maxval_reg     <= 17'd0;
            channel_reg    <= 2'd0;
            red_reg        <= 17'd0;
            green_reg      <= 17'd0;
            pixels_reg     <= 33'd0;
            error_reg      <= ppmp_pkg::ERR_NONE;
        end
        else if (in_accept && in_last)
        begin
            phase_reg      <= PH_MAGIC;
            in_token_reg   <= 1'b0;
            in_comment_reg <= 1'b0;
            magic_reg      <= MM_NONE;
            value_reg      <= 17'd0;
            bad_reg        <= 1'b0;
            long_reg       <= 1'b0;
            count_reg      <= '0;
            width_reg      <= '0;
            height_reg     <= '0;
            maxval_reg     <= 17'd0;
            channel_reg    <= 2'd0;
            red_reg        <= 17'd0;
            green_reg      <= 17'd0;
            pixels_reg     <= 33'd0;
            error_reg      <= ppmp_pkg::ERR_NONE;
        end
        else if (in_accept)
        begin
            phase_reg      <= phase_next;
            in_token_reg   <= in_token_next;
            in_comment_reg <= in_comment_next;
            magic_reg      <= magic_next;
            value_reg      <= value_next;
            bad_reg        <= bad_next;
            long_reg       <= long_next;
            count_reg      <= count_next;
            width_reg      <= width_next;
            height_reg     <= height_next;
            maxval_reg     <= maxval_next;
            channel_reg    <= channel_next;
            red_reg        <= red_next;
            green_reg      <= green_next;
            pixels_reg     <= pixels_next;
            error_reg      <= error_next;
        end
    end

endmodule

// ===== rtl/ppmp_skid.sv =====
// Two-entry output buffer that keeps the input ready registered.
module ppmp_skid (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  ppmp_pkg::result_t  in_data,
    output logic               in_ready,
    output logic               out_valid,
    output ppmp_pkg::result_t  out_data,
    input  logic               out_ready
);

    logic              out_valid_reg;
    logic              skid_valid_reg;
    ppmp_pkg::result_t out_data_reg;
    ppmp_pkg::result_t skid_data_reg;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Advance the output stage or park the new result in the skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_valid;
            end
        end
        else if (in_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Move payload alongside the valid bits
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_ready)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end
        else if (in_valid)
        begin
            skid_data_reg <= in_data;
        end
    end

endmodule

// ===== rtl/ppm_ascii_stream_parser.sv =====
// Top level of the PPM P3 ASCII stream parser.
// Takes one byte of a P3 file per transfer on s_* (s_tlast on the final byte) and returns one
// registered result per byte on m_*; a byte can be taken every cycle while s_tready is high.
// m_tuser gives the kind (nothing, header complete, pixel, file ended correctly, error) and
// m_tdata carries the pixel samples, header values and sticky error code. The whole per-byte
// update (token, header and pixel state) sits between the parse registers and a two-entry
// output buffer, so s_tready is registered and stays high unless two results are waiting.
module ppm_ascii_stream_parser #(
    parameter int MAX_TOKEN_LEN = 16,
    parameter int DIM_BITS      = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // data_byte[7:0]
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // red[16:0], green[33:17], blue[50:34], image_width[66:51], image_height[82:67],
    // max_value[99:83], error_code[102:100], zero pad[103]
    output logic [ppmp_pkg::TDATA_W-1:0] m_tdata,
    output logic [2:0]   m_tuser    // kind[2:0]
);

    logic              accept;
    ppmp_pkg::result_t parse_result;
    ppmp_pkg::result_t out_result;

    assign accept = s_tvalid && s_tready;

    // Parse one byte per transfer
    ppmp_parser #(
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN),
        .DIM_BITS      (DIM_BITS)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_accept (accept),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .result    (parse_result)
    );

    // Buffer results toward the output stream
    ppmp_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .in_data   (parse_result),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_data  (out_result),
        .out_ready (m_tready)
    );

    // Pack the result fields
    assign m_tuser = out_result.kind;
    assign m_tdata = {1'b0, out_result.error_code, out_result.max_value,
                      out_result.image_height, out_result.image_width,
                      out_result.blue, out_result.green, out_result.red};

`ifndef SYNTHESIS
    // Input stalls only while results are waiting
    assert property (@(posedge clk) disable iff (!rst_n) !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

    // Pixel and header results carry no error code
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ppmp_pkg::KIND_PIXEL || m_tuser == ppmp_pkg::KIND_HEADER)
        |-> m_tdata[ppmp_pkg::ERR_MSB:ppmp_pkg::ERR_LSB] == ppmp_pkg::ERR_NONE)
        else $error("pixel or header result with error set");

    // Error results carry an error code
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == ppmp_pkg::KIND_ERROR
        |-> m_tdata[ppmp_pkg::ERR_MSB:ppmp_pkg::ERR_LSB] != ppmp_pkg::ERR_NONE)
        else $error("error result without error code");

    // A correct end of file carries no error code
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == ppmp_pkg::KIND_DONE
        |-> m_tdata[ppmp_pkg::ERR_MSB:ppmp_pkg::ERR_LSB] == ppmp_pkg::ERR_NONE)
        else $error("end of file result with error code");
`endif

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the PPM P3 ASCII stream parser with a byte-level parse predictor.
module testbench;

    // Parser limits at the default parameter values
    localparam int TOKEN_LEN_MAX = 16;
    localparam int DIM_LIMIT = (1 << 16) - 1;
    localparam int VALUE_CAP = 65537;
    localparam longint unsigned PIXEL_COUNT_CAP = 64'h1_FFFF_FFFF;

    // Character codes
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_THREE = 8'h33;
    localparam logic [7:0] CH_SIX   = 8'h36;

    typedef enum logic [2:0] {
        PH_MAGIC,
        PH_WIDTH,
        PH_HEIGHT,
        PH_MAXVAL,
        PH_PIXELS
    } parse_phase_e;

    typedef enum logic [2:0] {
        TAG_NONE,
        TAG_P,
        TAG_P3,
        TAG_P6,
        TAG_OTHER
    } magic_tag_e;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = 8'h00;
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;
    logic [2:0]   m_tuser;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int mismatches = 0;
    int bytes_sent = 0;
    int files_sent = 0;
    int header_results = 0;
    int pixel_results = 0;
    int clean_ends = 0;
    int error_results = 0;

    ppmp_pkg::result_t pending_results[$];
    logic [7:0]        file_bytes[$];
    string             field_names[8] = '{"kind", "red", "green", "blue", "image_width",
                                          "image_height", "max_value", "error_code"};

    // Predictor state
    parse_phase_e      cur_phase;
    logic              tok_open;
    logic              comment_open;
    magic_tag_e        tok_tag;
    int                tok_value;
    logic              tok_bad;
    logic              tok_overlong;
    int                tok_len;
    logic [15:0]       hdr_width;
    logic [15:0]       hdr_height;
    logic [16:0]       hdr_maxval;
    int                chan_next;
    logic [16:0]       red_held;
    logic [16:0]       green_held;
    longint unsigned   pix_count;
    logic [2:0]        err_sticky;
    ppmp_pkg::result_t step_result;

    always #5 clk = ~clk;

    ppm_ascii_stream_parser dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Return the predictor to its power-up state
    function automatic void clear_parser();
        cur_phase = PH_MAGIC;
        tok_open = 1'b0;
        comment_open = 1'b0;
        tok_tag = TAG_NONE;
        tok_value = 0;
        tok_bad = 1'b0;
        tok_overlong = 1'b0;
        tok_len = 0;
        hdr_width = '0;
        hdr_height = '0;
        hdr_maxval = '0;
        chan_next = 0;
        red_held = '0;
        green_held = '0;
        pix_count = 0;
        err_sticky = ppmp_pkg::ERR_NONE;
    endfunction

    function automatic void raise_error(input logic [2:0] code);
        err_sticky = code;
        step_result.kind = ppmp_pkg::KIND_ERROR;
    endfunction

    // Append one non-space character to the open token
    function automatic void append_char(input logic [7:0] c);
        if (tok_len == 0)
            tok_tag = (c == CH_P) ? TAG_P : TAG_OTHER;
        else if (tok_tag == TAG_P)
            tok_tag = (c == CH_THREE) ? TAG_P3 : (c == CH_SIX) ? TAG_P6 : TAG_OTHER;
        else
            tok_tag = TAG_OTHER;

        if (tok_len >= TOKEN_LEN_MAX)
            tok_overlong = 1'b1;
        else
            tok_len++;

        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            tok_value = tok_value * 10 + int'(c - CH_ZERO);
            if (tok_value > VALUE_CAP)
                tok_value = VALUE_CAP;
        end
        else
            tok_bad = 1'b1;
        tok_open = 1'b1;
    endfunction

    // Finish the open token and apply it to the header or pixel state
    function automatic void close_token();
        int         v;
        logic       bad;
        logic       overlong;
        magic_tag_e tag;

        v = tok_value;
        bad = tok_bad;
        overlong = tok_overlong;
        tag = tok_tag;
        tok_open = 1'b0;
        tok_value = 0;
        tok_bad = 1'b0;
        tok_overlong = 1'b0;
        tok_len = 0;
        tok_tag = TAG_NONE;

        if (cur_phase == PH_MAGIC)
        begin
            if (tag == TAG_P6)
                raise_error(ppmp_pkg::ERR_P6);
            else if (tag == TAG_P3)
                cur_phase = PH_WIDTH;
            return;
        end
        if (bad)
        begin
            raise_error(ppmp_pkg::ERR_BAD_CHAR);
            return;
        end
        if (overlong)
        begin
            raise_error(ppmp_pkg::ERR_RANGE);
            return;
        end

        case (cur_phase)
            PH_WIDTH, PH_HEIGHT:
            begin
                if (v > DIM_LIMIT)
                begin
                    raise_error(ppmp_pkg::ERR_RANGE);
                    return;
                end
                if (cur_phase == PH_WIDTH)
                begin
                    hdr_width = v[15:0];
                    cur_phase = PH_HEIGHT;
                end
                else
                begin
                    hdr_height = v[15:0];
                    cur_phase = PH_MAXVAL;
                end
            end
            PH_MAXVAL:
            begin
                if (v > int'(ppmp_pkg::SAMPLE_LIMIT))
                begin
                    raise_error(ppmp_pkg::ERR_MAXVAL);
                    return;
                end
                hdr_maxval = v[16:0];
                cur_phase = PH_PIXELS;
                step_result.kind = ppmp_pkg::KIND_HEADER;
            end
            default:
            begin
                if (v > int'(hdr_maxval))
                begin
                    raise_error(ppmp_pkg::ERR_SAMPLE);
                    return;
                end
                if (chan_next == 0)
                begin
                    red_held = v[16:0];
                    chan_next = 1;
                end
                else if (chan_next == 1)
                begin
                    green_held = v[16:0];
                    chan_next = 2;
                end
                else
                begin
                    step_result.kind = ppmp_pkg::KIND_PIXEL;
                    step_result.red = red_held;
                    step_result.green = green_held;
                    step_result.blue = v[16:0];
                    chan_next = 0;
                    if (pix_count < PIXEL_COUNT_CAP)
                        pix_count++;
                end
            end
        endcase
    endfunction

    // Predict the result of one accepted byte
    function automatic ppmp_pkg::result_t parse_byte(input logic [7:0] c, input logic last);
        longint unsigned   need;
        ppmp_pkg::result_t r;

        step_result = '0;
        step_result.kind = ppmp_pkg::KIND_NONE;

        if (err_sticky == ppmp_pkg::ERR_NONE)
        begin
            if (comment_open)
            begin
                if (c == CH_LF)
                    comment_open = 1'b0;
            end
            else if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))
            begin
                if (tok_open)
                    close_token();
            end
            else if (c == CH_HASH)
            begin
                if (tok_open)
                    close_token();
                comment_open = 1'b1;
            end
            else
                append_char(c);
        end

        // Close out the file on its last byte
        if (last)
        begin
            if (err_sticky == ppmp_pkg::ERR_NONE && tok_open)
                close_token();
            comment_open = 1'b0;
            if (err_sticky == ppmp_pkg::ERR_NONE)
            begin
                need = 64'(hdr_width) * 64'(hdr_height);
                if (cur_phase != PH_PIXELS)
                    err_sticky = ppmp_pkg::ERR_TOO_FEW;
                else if (pix_count > need)
                    err_sticky = ppmp_pkg::ERR_TOO_MANY;
                else if (pix_count < need)
                    err_sticky = ppmp_pkg::ERR_TOO_FEW;
            end
            step_result.kind = (err_sticky != ppmp_pkg::ERR_NONE) ? ppmp_pkg::KIND_ERROR
                                                                  : ppmp_pkg::KIND_DONE;
        end

        step_result.image_width = hdr_width;
        step_result.image_height = hdr_height;
        step_result.max_value = hdr_maxval;
        step_result.error_code = err_sticky;
        r = step_result;
        if (last)
            clear_parser();
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < 20)
            $display("MISMATCH at %0t: %s", $time, msg);
        mismatches++;
    endtask

    // Drive one byte, wait for its transfer and queue its expected result
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= last;
        do
            @(posedge clk);
        while (!s_tready);
        pending_results.push_back(parse_byte(b, last));
        bytes_sent++;
    endtask

    task automatic send_file();
        for (int i = 0; i < file_bytes.size(); i++)
            send_byte(file_bytes[i], i == file_bytes.size() - 1);
        files_sent++;
    endtask

    // Compare each result transfer with the oldest expectation
    task automatic check_result();
        ppmp_pkg::result_t want;
        logic [31:0]       got_f[8];
        logic [31:0]       want_f[8];

        case (m_tuser)
            ppmp_pkg::KIND_HEADER: header_results++;
            ppmp_pkg::KIND_PIXEL:  pixel_results++;
            ppmp_pkg::KIND_DONE:   clean_ends++;
            ppmp_pkg::KIND_ERROR:  error_results++;
            default:               ;
        endcase
        if (pending_results.size() == 0)
        begin
            report_mismatch("result with no expectation waiting");
            return;
        end
        want = pending_results.pop_front();
        got_f[0] = 32'(m_tuser);
        got_f[1] = 32'(m_tdata[16:0]);
        got_f[2] = 32'(m_tdata[33:17]);
        got_f[3] = 32'(m_tdata[50:34]);
        got_f[4] = 32'(m_tdata[66:51]);
        got_f[5] = 32'(m_tdata[82:67]);
        got_f[6] = 32'(m_tdata[99:83]);
        got_f[7] = 32'(m_tdata[ppmp_pkg::ERR_MSB:ppmp_pkg::ERR_LSB]);
        want_f[0] = 32'(want.kind);
        want_f[1] = 32'(want.red);
        want_f[2] = 32'(want.green);
        want_f[3] = 32'(want.blue);
        want_f[4] = 32'(want.image_width);
        want_f[5] = 32'(want.image_height);
        want_f[6] = 32'(want.max_value);
        want_f[7] = 32'(want.error_code);
        for (int i = 0; i < 8; i++)
            if (got_f[i] !== want_f[i])
                report_mismatch($sformatf("%s got %0d expected %0d",
                                          field_names[i], got_f[i], want_f[i]));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            check_result();
    end

    // Stall the result side at random
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // File building helpers
    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            file_bytes.push_back(s[i]);
    endtask

    function automatic logic [7:0] pick_space();
        case ($urandom_range(0, 5))
            0: return CH_TAB;
            1: return CH_LF;
            2: return CH_VT;
            3: return CH_FF;
            4: return CH_CR;
            default: return CH_SPACE;
        endcase
    endfunction

    // Whitespace run, or now and then a comment up to a newline
    task automatic add_gap();
        logic [7:0] b;

        if ($urandom_range(0, 9) == 0)
        begin
            file_bytes.push_back(CH_HASH);
            repeat ($urandom_range(0, 6))
            begin
                b = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                : 8'($urandom_range(32, 126));
                file_bytes.push_back((b == CH_LF) ? CH_SPACE : b);
            end
            file_bytes.push_back(CH_LF);
        end
        else
            repeat ($urandom_range(1, 3))
                file_bytes.push_back(pick_space());
    endtask

    // Decimal token, sometimes with leading zeros up to or past the length limit
    task automatic add_number(input longint unsigned v);
        string s;
        int    zeros;
        int    r;

        s = $sformatf("%0d", v);
        r = $urandom_range(0, 19);
        zeros = 0;
        if (r == 0)
            zeros = TOKEN_LEN_MAX + 1 - s.len();
        else if (r == 1)
            zeros = TOKEN_LEN_MAX - s.len();
        else if (r < 4)
            zeros = $urandom_range(1, 3);
        repeat (zeros)
            file_bytes.push_back(CH_ZERO);
        add_text(s);
    endtask

    function automatic longint unsigned pick_dim();
        if ($urandom_range(0, 9) < 8)
            return 64'($urandom_range(0, 3));
        case ($urandom_range(0, 3))
            0: return 65535;
            1: return 65536;
            2: return 99999;
            default: return 64'd4294967296;
        endcase
    endfunction

    function automatic longint unsigned pick_maxval();
        case ($urandom_range(0, 19))
            0: return 0;
            1: return 1;
            2: return 65535;
            3: return 65536;
            4: return 65537;
            5: return 99999999;
            6, 7: return 64'($urandom_range(0, 1023));
            default: return 64'($urandom_range(1, 255));
        endcase
    endfunction

    function automatic longint unsigned pick_sample(input longint unsigned mv);
        case ($urandom_range(0, 19))
            0: return mv;
            1: return mv + 1;
            2: return 0;
            default: return 64'($urandom_range(0, int'(mv > 65536 ? 65536 : mv)));
        endcase
    endfunction

    // Well-formed file with random content and occasional count or range faults
    task automatic build_well_formed();
        longint unsigned w;
        longint unsigned h;
        longint unsigned mv;
        int              n;
        int              r;

        file_bytes.delete();
        w = pick_dim();
        h = pick_dim();
        mv = pick_maxval();
        n = (w * h > 12) ? int'($urandom_range(0, 3)) : int'(w * h);
        r = $urandom_range(0, 11);
        if (r == 0)
            n++;
        else if (r == 1 && n > 0)
            n--;

        if ($urandom_range(0, 1))
            add_gap();
        if ($urandom_range(0, 4) == 0)
        begin
            case ($urandom_range(0, 5))
                0: add_text("P");
                1: add_text("P33");
                2: add_text("p3");
                3: add_text("X1");
                4: add_text("3P");
                default: add_text("P36");
            endcase
            add_gap();
        end
        add_text("P3");
        add_gap();
        add_number(w);
        add_gap();
        add_number(h);
        add_gap();
        add_number(mv);
        repeat (n)
            repeat (3)
            begin
                add_gap();
                add_number(pick_sample(mv));
            end
        // Leave a partial triplet now and then
        if (r == 2)
        begin
            add_gap();
            add_number(pick_sample(mv));
        end

        case ($urandom_range(0, 9))
            0:
            begin
                add_gap();
                add_text("#end");
            end
            1, 2, 3, 4: add_gap();
            default: ;
        endcase
    endtask

    // Tests
    task automatic test_minimal_files();
        // Valid file: comment first, mixed whitespace, full-scale maxval and samples
        file_bytes.delete();
        add_text("#\nP3\t1");
        file_bytes.push_back(CH_FF);
        add_text("1\r65536");
        file_bytes.push_back(CH_VT);
        add_text("65536 0 7");
        send_file();
        // Binary magic, closed by the last byte
        file_bytes.delete();
        add_text("P6 ");
        send_file();
        // Single-byte files with the extreme byte values
        file_bytes.delete();
        file_bytes.push_back(8'hFF);
        send_file();
        file_bytes.delete();
        file_bytes.push_back(8'h00);
        send_file();
    endtask

    task automatic test_well_formed_files(input int byte_target);
        int start;

        start = bytes_sent;
        while (bytes_sent - start < byte_target)
        begin
            build_well_formed();
            send_file();
        end
    endtask

    // Noise, mutated or truncated files and binary magic
    task automatic test_broken_files(input int byte_target);
        int start;
        int k;

        start = bytes_sent;
        while (bytes_sent - start < byte_target)
        begin
            case ($urandom_range(0, 5))
                0, 1:
                begin
                    file_bytes.delete();
                    repeat ($urandom_range(1, 24))
                        file_bytes.push_back(8'($urandom_range(0, 255)));
                end
                2, 3:
                begin
                    build_well_formed();
                    k = $urandom_range(0, file_bytes.size() - 1);
                    file_bytes[k] = 8'($urandom_range(0, 255));
                end
                4:
                begin
                    build_well_formed();
                    k = $urandom_range(1, file_bytes.size());
                    while (file_bytes.size() > k)
                        void'(file_bytes.pop_back());
                end
                default:
                begin
                    file_bytes.delete();
                    add_text("P6");
                    add_gap();
                    add_text("1 1 255\n");
                end
            endcase
            send_file();
        end
    endtask

    initial
    begin
        clear_parser();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 31;
        rx_idle_pct = 87;
        test_minimal_files();
        test_well_formed_files(340);
        test_broken_files(300);

        tx_idle_pct = 87;
        rx_idle_pct = 31;
        test_well_formed_files(340);
        test_broken_files(300);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_well_formed_files(340);
        test_broken_files(300);
        s_tvalid <= 1'b0;

        // Drain outstanding results, then allow for pipeline slack
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Sent %0d bytes in %0d files; saw %0d headers, %0d pixels,",
                 bytes_sent, files_sent, header_results, pixel_results);
        $display("%0d clean file ends and %0d error results; %0d mismatches",
                 clean_ends, error_results, mismatches);
        if (mismatches == 0)
            $display("ppm_ascii_stream_parser test passed");
        else
            $display("ppm_ascii_stream_parser test failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("ppm_ascii_stream_parser test failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/ppmp_pkg.sv
rtl/ppmp_parser.sv
rtl/ppmp_skid.sv
rtl/ppm_ascii_stream_parser.sv
bench/testbench.sv
